### rtl/core/mme_pkg.sv
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int ACC_W       = PROD_W + 4;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             first;
    logic             last;
    logic             last_all;
    logic             err;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } dp_cmd_t;

endpackage

### rtl/core/matrix_multiply_engine.sv
// Load items (operation 0 or 1) write one element of A or B and give no result;
// loads may follow one another every cycle while busy is low. A start item with
// a_cols != b_rows gives one dim-error result the cycle after it is taken.
// Otherwise the engine reads one A/B pair per cycle through a single read port on
// each store and one multiplier, and busy stays high from the start until the pipe
// has drained; product elements appear in row-major order, each as a one-cycle
// out_valid strobe. The receiver cannot stall the block and must take every result
// in the cycle it is shown.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_operation,
  input  logic [IDX_W-1:0]     in_elem_row,
  input  logic [IDX_W-1:0]     in_elem_col,
  input  logic [VALUE_W-1:0]   in_elem_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 out_valid,
  output logic [IDX_W-1:0]     out_row,
  output logic [IDX_W-1:0]     out_col,
  output logic [VALUE_W-1:0]   out_value,
  output logic                 out_last,
  output logic                 out_dim_error
);

  dp_cmd_t cmd;
  logic    pipe_busy;

  mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pipe_busy    (pipe_busy),
    .busy         (busy),
    .cmd          (cmd)
  );

  mme_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .wr_row        (in_elem_row),
    .wr_col        (in_elem_col),
    .wr_value      (in_elem_value),
    .pipe_busy     (pipe_busy),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_last      (out_last),
    .out_dim_error (out_dim_error)
  );

endmodule

### rtl/core/mme_ctrl.sv
module mme_ctrl import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_operation,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 pipe_busy,
  output logic                 busy,
  output dp_cmd_t              cmd
);

  state_t state_r, state_nxt;
  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [IDX_W-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic             accept;
  logic             k_end, j_end, i_end;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(8);
      a_cols_r <= DIM_W'(8);
      b_rows_r <= DIM_W'(8);
      b_cols_r <= DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_A_ROWS: a_rows_r <= cfg_data;
        CFG_A_COLS: a_cols_r <= cfg_data;
        CFG_B_ROWS: b_rows_r <= cfg_data;
        CFG_B_COLS: b_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ar = clamp_dim(a_rows_r);
  assign ac = clamp_dim(a_cols_r);
  assign br = clamp_dim(b_rows_r);
  assign bc = clamp_dim(b_cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign k_end  = (DIM_W'(k_r) == ac - DIM_W'(1));
  assign j_end  = (DIM_W'(j_r) == bc - DIM_W'(1));
  assign i_end  = (DIM_W'(i_r) == ar - DIM_W'(1));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.k     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.wr_a = (in_operation == OP_LOAD_A);
          cmd.wr_b = (in_operation == OP_LOAD_B);
          if (in_operation == OP_START) begin
            if (ac != br) begin
              cmd.err = 1'b1;
            end else begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        // one (i,k)/(k,j) read pair per cycle; the tags ride along the pipe
        cmd.rd_en    = 1'b1;
        cmd.first    = (k_r == '0);
        cmd.last     = k_end;
        cmd.last_all = k_end && j_end && i_end;
        if (!k_end) begin
          k_nxt = k_r + IDX_W'(1);
        end else begin
          k_nxt = '0;
          if (!j_end) begin
            j_nxt = j_r + IDX_W'(1);
          end else begin
            j_nxt = '0;
            if (!i_end) i_nxt = i_r + IDX_W'(1);
            else state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/mme_datapath.sv
module mme_datapath import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [IDX_W-1:0]   wr_row,
  input  logic [IDX_W-1:0]   wr_col,
  input  logic [VALUE_W-1:0] wr_value,
  output logic               pipe_busy,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_row,
  output logic [IDX_W-1:0]   out_col,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last,
  output logic               out_dim_error
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AIDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VALUE_W-1:0] mem_a [DEPTH];
  logic [VALUE_W-1:0] mem_b [DEPTH];

  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic              wr_in_range;

  logic signed [VALUE_W-1:0] a_q_r, b_q_r;
  logic                      rd_vld_r, rd_first_r, rd_last_r, rd_all_r;
  logic [IDX_W-1:0]          rd_i_r, rd_j_r;

  logic signed [PROD_W-1:0]  prod_r;
  logic                      mul_vld_r, mul_first_r, mul_last_r, mul_all_r;
  logic [IDX_W-1:0]          mul_i_r, mul_j_r;

  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W-FRAC_W-VALUE_W:0] acc_top;
  logic [VALUE_W-1:0]        sat_value;

  logic               out_valid_r, out_last_r, out_err_r;
  logic [IDX_W-1:0]   out_row_r, out_col_r;
  logic [VALUE_W-1:0] out_value_r;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r[AIDX_W-1:0]) * ADDR_W'(MAX_DIM) + ADDR_W'(c[AIDX_W-1:0]);
  endfunction

  assign wr_in_range = (32'(wr_row) < 32'(MAX_DIM)) && (32'(wr_col) < 32'(MAX_DIM));
  assign wr_addr     = cell_addr(wr_row, wr_col);
  assign rd_addr_a   = cell_addr(cmd.i, cmd.k);
  assign rd_addr_b   = cell_addr(cmd.k, cmd.j);

  always_ff @(posedge clk) begin
    if (cmd.wr_a && wr_in_range) mem_a[wr_addr] <= wr_value;
    if (cmd.rd_en) a_q_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b && wr_in_range) mem_b[wr_addr] <= wr_value;
    if (cmd.rd_en) b_q_r <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.rd_en;
      mul_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r  <= cmd.first;
    rd_last_r   <= cmd.last;
    rd_all_r    <= cmd.last_all;
    rd_i_r      <= cmd.i;
    rd_j_r      <= cmd.j;
    prod_r      <= a_q_r * b_q_r;
    mul_first_r <= rd_first_r;
    mul_last_r  <= rd_last_r;
    mul_all_r   <= rd_all_r;
    mul_i_r     <= rd_i_r;
    mul_j_r     <= rd_j_r;
  end

  assign pipe_busy = rd_vld_r | mul_vld_r;

  assign acc_nxt = mul_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  // in range when every bit from 2^47 upward equals the sign
  assign acc_top   = acc_nxt[ACC_W-1:FRAC_W+VALUE_W-1];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) sat_value = acc_nxt[FRAC_W+VALUE_W-1:FRAC_W];
    else if (acc_nxt[ACC_W-1]) sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
    else sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (mul_vld_r) acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (mul_vld_r && mul_last_r) || cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end else if (mul_vld_r && mul_last_r) begin
      out_row_r   <= mul_i_r;
      out_col_r   <= mul_j_r;
      out_value_r <= sat_value;
      out_last_r  <= mul_all_r;
      out_err_r   <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_dim_error = out_err_r;

endmodule

### dv/tb_matrix_multiply_engine.sv
module tb_matrix_multiply_engine;
  import mme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = MAX_DIM_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [ACC_W+3:0] Q_HI = 72'sd2147483647;
  localparam logic signed [ACC_W+3:0] Q_LO = -72'sd2147483648;

  typedef struct {
    logic [1:0]         op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    bit                 drain;
  } mm_item_t;

  typedef struct {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               err;
  } c_elem_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_operation = '0;
  logic [IDX_W-1:0]     in_elem_row = '0;
  logic [IDX_W-1:0]     in_elem_col = '0;
  logic [VALUE_W-1:0]   in_elem_value = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_row;
  logic [IDX_W-1:0]     out_col;
  logic [VALUE_W-1:0]   out_value;
  logic                 out_last;
  logic                 out_dim_error;

  matrix_multiply_engine dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_elem_row, .in_elem_col, .in_elem_value,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_row, .out_col, .out_value, .out_last, .out_dim_error
  );

  // predictor state
  logic [VALUE_W-1:0] mat_a [DIM*DIM];
  logic [VALUE_W-1:0] mat_b [DIM*DIM];
  logic [DIM_W-1:0]   dim_reg [4] = '{4'd8, 4'd8, 4'd8, 4'd8};

  // generator bookkeeping: which cells have been loaded so far
  bit [DIM*DIM-1:0] a_loaded;
  bit [DIM*DIM-1:0] b_loaded;

  logic [VALUE_W-1:0] b_row_vals [8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                         32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                                         32'h0000_0001, 32'h5555_AAAA};

  mm_item_t mm_items [$];
  c_elem_t  c_due [$];
  mm_item_t cur;
  c_elem_t  want_e;

  int in_flight = 0;
  int gap_pct = 0;
  int n_pushed = 0;
  int n_items = 0;
  int n_starts = 0;
  int n_dim_errs = 0;
  int n_elems = 0;
  int n_settings = 0;
  int fails = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > DIM) return DIM;
    return int'(r);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_q();
    logic [VALUE_W-1:0] mag;
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: begin
        // within +/-16.0, keeps sums clear of saturation
        mag = $urandom_range(32'h000F_FFFF);
        return $urandom_range(1) ? -mag : mag;
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic compute_products(input mm_item_t it);
    int ar, ac, br, bc, i, j, k;
    logic signed [2*VALUE_W-1:0] prod;
    logic signed [ACC_W+3:0]     acc;
    logic signed [ACC_W+3:0]     flo;
    c_elem_t e;
    case (it.op)
      OP_LOAD_A: mat_a[it.row*DIM + it.col] = it.value;
      OP_LOAD_B: mat_b[it.row*DIM + it.col] = it.value;
      OP_START: begin
        n_starts++;
        ar = eff_dim(dim_reg[CFG_A_ROWS]);
        ac = eff_dim(dim_reg[CFG_A_COLS]);
        br = eff_dim(dim_reg[CFG_B_ROWS]);
        bc = eff_dim(dim_reg[CFG_B_COLS]);
        if (ac != br) begin
          n_dim_errs++;
          e = '{row: '0, col: '0, value: '0, last: 1'b1, err: 1'b1};
          c_due.push_back(e);
        end else begin
          for (i = 0; i < ar; i++) begin
            for (j = 0; j < bc; j++) begin
              acc = '0;
              for (k = 0; k < ac; k++) begin
                prod = $signed(mat_a[i*DIM + k]) * $signed(mat_b[k*DIM + j]);
                acc = acc + prod;
              end
              // floor to Q16.16, then clamp
              flo = acc >>> FRAC_W;
              e.row = i[IDX_W-1:0];
              e.col = j[IDX_W-1:0];
              if (flo > Q_HI) e.value = 32'h7FFF_FFFF;
              else if (flo < Q_LO) e.value = 32'h8000_0000;
              else e.value = flo[VALUE_W-1:0];
              e.last = (i == ar - 1) && (j == bc - 1);
              e.err = 1'b0;
              c_due.push_back(e);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        compute_products(cur);
        in_flight--;
        n_items++;
      end
      if (!start || !busy) begin
        if (mm_items.size() != 0 && mm_items[0].drain && in_flight == 0 && c_due.size() == 0)
          mm_items.delete(0);
        if (mm_items.size() != 0 && !mm_items[0].drain && $urandom_range(99) >= gap_pct) begin
          cur = mm_items.pop_front();
          in_flight++;
          start <= 1'b1;
          in_operation <= cur.op;
          in_elem_row <= cur.row;
          in_elem_col <= cur.col;
          in_elem_value <= cur.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s of C[%0d][%0d] expected %h actual %h", $time, what,
               want_e.row, want_e.col, want, got);
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (c_due.size() == 0) begin
        fails++;
        $display("%0t: unexpected result expected none actual row %0d col %0d value %h",
                 $time, out_row, out_col, out_value);
      end else begin
        want_e = c_due.pop_front();
        n_elems++;
        check_field("row", want_e.row, out_row);
        check_field("col", want_e.col, out_col);
        check_field("value", want_e.value, out_value);
        check_field("last", want_e.last, out_last);
        check_field("dim_error", want_e.err, out_dim_error);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] op, input int row, input int col,
                           input logic [VALUE_W-1:0] value);
    mm_item_t it;
    it = '{op: op, row: row[IDX_W-1:0], col: col[IDX_W-1:0], value: value, drain: 1'b0};
    mm_items.push_back(it);
    if (op != OP_UNUSED) n_pushed++;
    if (op == OP_LOAD_A) a_loaded[row*DIM + col] = 1'b1;
    if (op == OP_LOAD_B) b_loaded[row*DIM + col] = 1'b1;
  endtask

  // when a_cols matches b_rows, loads any cell the product would read that has never been written; then starts
  task automatic push_start();
    int ar, ac, br, bc, i, j, k;
    ar = eff_dim(dim_reg[CFG_A_ROWS]);
    ac = eff_dim(dim_reg[CFG_A_COLS]);
    br = eff_dim(dim_reg[CFG_B_ROWS]);
    bc = eff_dim(dim_reg[CFG_B_COLS]);
    if (ac == br) begin
      for (i = 0; i < ar; i++)
        for (k = 0; k < ac; k++)
          if (!a_loaded[i*DIM + k]) push_item(OP_LOAD_A, i, k, rand_q());
      for (k = 0; k < ac; k++)
        for (j = 0; j < bc; j++)
          if (!b_loaded[k*DIM + j]) push_item(OP_LOAD_B, k, j, rand_q());
    end
    push_item(OP_START, $urandom_range(7), $urandom_range(7), $urandom());
  endtask

  task automatic wait_idle();
    while (mm_items.size() != 0 || in_flight != 0 || c_due.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    dim_reg[idx] = val;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] r0, r1, r2, r3);
    wait_idle();
    cfg_write(CFG_A_ROWS, r0);
    cfg_write(CFG_A_COLS, r1);
    cfg_write(CFG_B_ROWS, r2);
    cfg_write(CFG_B_COLS, r3);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_phase(input logic [DIM_W-1:0] r0, r1, r2, r3,
                              input int pct, input int n);
    int target, ar, ac, bc, pick, jobs;
    mm_item_t hold;
    set_dims(r0, r1, r2, r3);
    gap_pct = pct;
    target = n_pushed + n;
    jobs = 0;
    ar = eff_dim(r0);
    ac = eff_dim(r1);
    bc = eff_dim(r3);
    hold = '{op: '0, row: '0, col: '0, value: '0, drain: 1'b1};
    while (n_pushed < target) begin
      pick = $urandom_range(99);
      jobs++;
      if (pick < 70) begin
        // refresh up to three cells inside the product, then start
        repeat ($urandom_range(3)) begin
          if ($urandom_range(1))
            push_item(OP_LOAD_A, $urandom_range(ar - 1), $urandom_range(ac - 1), rand_q());
          else
            push_item(OP_LOAD_B, $urandom_range(ac - 1), $urandom_range(bc - 1), rand_q());
        end
        push_start();
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 1))
          push_item($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A, $urandom_range(7),
                    $urandom_range(7), rand_q());
      end else if (pick < 93) begin
        push_item(OP_UNUSED, $urandom_range(7), $urandom_range(7), $urandom());
      end else begin
        push_start();
        push_start();
      end
      // sender holds off until every due element is out
      if (jobs == 1 || $urandom_range(9) == 0) mm_items.push_back(hold);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // a_cols (8) against b_rows (3): error item
    gap_pct = 0;
    set_dims(4'd8, 4'd8, 4'd3, 4'd8);
    push_item(OP_UNUSED, 7, 7, 32'hFFFF_FFFF);
    push_item(OP_START, 0, 0, 32'h0);

    // zero and oversized registers clamp: 1x1 times 1x8
    set_dims(4'd1, 4'd0, 4'd1, 4'd15);
    push_item(OP_LOAD_A, 0, 0, 32'h7FFF_FFFF);
    foreach (b_row_vals[j]) push_item(OP_LOAD_B, 0, j, b_row_vals[j]);
    push_item(OP_LOAD_A, 7, 7, 32'h8000_0000);
    push_item(OP_UNUSED, 0, 0, 32'h0);
    push_start();

    // 1x1: positive saturation, exact value, floor of a negative fraction
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    push_item(OP_LOAD_A, 0, 0, 32'h8000_0000);
    push_item(OP_LOAD_B, 0, 0, 32'h8000_0000);
    push_start();
    push_item(OP_LOAD_A, 0, 0, 32'h0001_8000);
    push_item(OP_LOAD_B, 0, 0, 32'hFFFF_0000);
    push_start();
    push_item(OP_LOAD_A, 0, 0, 32'h0000_0001);
    push_item(OP_LOAD_B, 0, 0, 32'hFFFF_FFFF);
    push_start();

    random_phase(4'd1, 4'd1, 4'd1, 4'd1, 0, 24);
    random_phase(4'd0, 4'd0, 4'd0, 4'd0, 72, 24);
    random_phase(4'd3, 4'd5, 4'd5, 4'd2, 6, 24);
    random_phase(4'd15, 4'd15, 4'd15, 4'd15, 0, 24);
    random_phase(4'd8, 4'd8, 4'd8, 4'd8, 72, 24);
    random_phase(4'd4, 4'd8, 4'd2, 4'd6, 6, 24);
    random_phase(DIM_W'($urandom_range(15)), DIM_W'($urandom_range(15)),
                 DIM_W'($urandom_range(15)), DIM_W'($urandom_range(15)), 0, 24);
    random_phase(DIM_W'($urandom_range(15)), DIM_W'($urandom_range(15)),
                 DIM_W'($urandom_range(15)), DIM_W'($urandom_range(15)), 72, 24);
    random_phase(DIM_W'($urandom_range(15)), DIM_W'($urandom_range(15)),
                 DIM_W'($urandom_range(15)), DIM_W'($urandom_range(15)), 6, 24);

    wait_idle();
    $display("Run covered %0d items (%0d starts, %0d dimension errors) over %0d settings,",
             n_items, n_starts, n_dim_errs, n_settings);
    $display("with %0d result items checked in %0d cycles.", n_elems, cycles);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
